### src/nb3_pkg.sv
// ----------------------------------------------------------------------------
// nb3_pkg
// Shared widths, pipeline depth, register indexes and control types of the
// normalised 3x3 blur.
// ----------------------------------------------------------------------------
package nb3_pkg;

  localparam int COORD_BITS  = 12;
  localparam int SAMPLE_BITS = 8;
  localparam int WEIGHT_BITS = 8;
  localparam int TAPS        = 9;
  localparam int ROW_W       = 3 * SAMPLE_BITS;
  localparam int WROW_W      = 3 * WEIGHT_BITS;
  localparam int DIM_W       = COORD_BITS + 1;
  localparam int CFG_W       = (WROW_W > DIM_W) ? WROW_W : DIM_W;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_W       = 8;
  localparam int ALPHA_W     = 8;

  localparam int TAP_W  = $clog2(TAPS + 1);
  localparam int NORM_W = WEIGHT_BITS + TAP_W;
  localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;
  localparam int ACC_W  = PROD_W + TAP_W;
  localparam int REM_W  = ACC_W + 1;

  // stage 0 weights, 1 products, 2 sums, then one stage per quotient bit
  localparam int NST = 3 + SAMPLE_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_W_TOP   = 3'd2,
    REG_W_MID   = 3'd3,
    REG_W_BOT   = 3'd4
  } nb3_reg_t;

  typedef struct packed {
    logic [NST-1:0] en;
  } nb3_ctrl_t;

endpackage

### src/nb3_lane.sv
// ----------------------------------------------------------------------------
// nb3_lane
// One colour channel: weighted products, tap sum with rounding offset and a
// restoring divider pipeline giving one quotient bit per stage.
// ----------------------------------------------------------------------------
module nb3_lane (
  input  logic                                          clk,
  input  nb3_pkg::nb3_ctrl_t                            ctrl,
  input  logic [nb3_pkg::ROW_W-1:0]                     in_above,
  input  logic [nb3_pkg::ROW_W-1:0]                     in_level,
  input  logic [nb3_pkg::ROW_W-1:0]                     in_below,
  input  logic [nb3_pkg::TAPS-1:0][nb3_pkg::WEIGHT_BITS-1:0] wt_s0,
  input  logic [nb3_pkg::NST-2:1][nb3_pkg::NORM_W-1:0]  norm_st,
  output logic [nb3_pkg::SAMPLE_BITS-1:0]               quot
);
  import nb3_pkg::*;

  logic [TAPS-1:0][SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic [TAPS-1:0][PROD_W-1:0]      prod_r, prod_nxt;
  logic [SAMPLE_BITS:0][REM_W-1:0]       rem_r, rem_nxt;
  logic [SAMPLE_BITS:0][SAMPLE_BITS-1:0] q_r, q_nxt;
  logic [ACC_W-1:0]                 acc;
  logic [REM_W-1:0]                 dv;

  // unpack the neighbourhood, left tap first
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      smp_nxt[c]     = in_above[c*SAMPLE_BITS +: SAMPLE_BITS];
      smp_nxt[3 + c] = in_level[c*SAMPLE_BITS +: SAMPLE_BITS];
      smp_nxt[6 + c] = in_below[c*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // products, sum and divider steps
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      prod_nxt[t] = PROD_W'(smp_r[t] * wt_s0[t]);
    end
    acc = '0;
    for (int t = 0; t < TAPS; t++) begin
      acc = acc + ACC_W'(prod_r[t]);
    end
    rem_nxt[0] = REM_W'(acc) + REM_W'(norm_st[1] >> 1);
    q_nxt[0]   = '0;
    dv         = '0;
    for (int k = 1; k <= SAMPLE_BITS; k++) begin
      dv = REM_W'(norm_st[1 + k]) << (SAMPLE_BITS - k);
      if (rem_r[k-1] >= dv) begin
        rem_nxt[k] = rem_r[k-1] - dv;
        q_nxt[k]   = q_r[k-1] | SAMPLE_BITS'(1 << (SAMPLE_BITS - k));
      end else begin
        rem_nxt[k] = rem_r[k-1];
        q_nxt[k]   = q_r[k-1];
      end
    end
  end

  // payload registers, moved by the stage enables
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) smp_r <= smp_nxt;
    if (ctrl.en[1]) prod_r <= prod_nxt;
    for (int k = 0; k <= SAMPLE_BITS; k++) begin
      if (ctrl.en[2 + k]) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign quot = q_r[SAMPLE_BITS];

endmodule

### src/normalized_3x3_blur.sv
// ----------------------------------------------------------------------------
// normalized_3x3_blur
// Weighted 3x3 RGB blur with renormalisation over in-frame taps.
// ----------------------------------------------------------------------------
// One transaction in, one out, at a sustained rate of one per cycle unless the
// output stalls; stalls collapse bubbles, so inputs keep being taken while
// empty stages remain. Tap masking, products, tap sum, then an 8-stage restoring
// divider in each of three channel lanes yields one quotient bit per stage.
// Write configuration by cfg_we/cfg_index/cfg_data only while idle (not enforced).
module normalized_3x3_blur (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [nb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nb3_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [nb3_pkg::ROW_W-1:0]        in_red_above,
  input  logic [nb3_pkg::ROW_W-1:0]        in_red_level,
  input  logic [nb3_pkg::ROW_W-1:0]        in_red_below,
  input  logic [nb3_pkg::ROW_W-1:0]        in_green_above,
  input  logic [nb3_pkg::ROW_W-1:0]        in_green_level,
  input  logic [nb3_pkg::ROW_W-1:0]        in_green_below,
  input  logic [nb3_pkg::ROW_W-1:0]        in_blue_above,
  input  logic [nb3_pkg::ROW_W-1:0]        in_blue_level,
  input  logic [nb3_pkg::ROW_W-1:0]        in_blue_below,
  input  logic [nb3_pkg::COORD_BITS-1:0]   in_pixel_column,
  input  logic [nb3_pkg::COORD_BITS-1:0]   in_pixel_row,
  input  logic [nb3_pkg::ALPHA_W-1:0]      in_center_alpha,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nb3_pkg::OUT_W-1:0]        out_red_out,
  output logic [nb3_pkg::OUT_W-1:0]        out_green_out,
  output logic [nb3_pkg::OUT_W-1:0]        out_blue_out,
  output logic [nb3_pkg::ALPHA_W-1:0]      out_alpha_out,
  output logic                             out_zero_weight
);
  import nb3_pkg::*;

  logic [DIM_W-1:0]  width_r, height_r;
  logic [WROW_W-1:0] wtop_r, wmid_r, wbot_r;

  logic [NST-1:0] v_r, v_nxt;
  logic [NST:0]   rdy;
  nb3_ctrl_t      ctrl;

  logic [2:0]                         xok, yok;
  logic [DIM_W-1:0]                   pos;
  logic [TAPS-1:0][WEIGHT_BITS-1:0]   wt_nxt, wt_r;
  logic [NST-2:1][NORM_W-1:0]         norm_r;
  logic [NORM_W-1:0]                  norm_nxt;
  logic [NST-1:0][2:0][SAMPLE_BITS-1:0] ctr_r;
  logic [NST-1:0][ALPHA_W-1:0]        alpha_r;
  logic [NST-1:1]                     zero_r;
  logic [SAMPLE_BITS-1:0]             q_red, q_green, q_blue;

  // configuration registers, low bits of the write kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(4096);
      height_r <= DIM_W'(4096);
      wtop_r   <= WROW_W'(24'h010101);
      wmid_r   <= WROW_W'(24'h010101);
      wbot_r   <= WROW_W'(24'h010101);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_W_TOP:  wtop_r   <= cfg_data[WROW_W-1:0];
        REG_W_MID:  wmid_r   <= cfg_data[WROW_W-1:0];
        REG_W_BOT:  wbot_r   <= cfg_data[WROW_W-1:0];
        default: ;
      endcase
    end
  end

  // stage readiness, each stage moves when it is empty or its successor moves
  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ctrl.en = rdy[NST-1:0];
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // in-frame test per column and row offset, out-of-frame taps get zero weight
  always_comb begin
    pos = '0;
    for (int c = 0; c < 3; c++) begin
      pos    = {1'b0, in_pixel_column} + DIM_W'(c) - DIM_W'(1);
      xok[c] = !(c == 0 && in_pixel_column == '0) && (pos < width_r);
      pos    = {1'b0, in_pixel_row} + DIM_W'(c) - DIM_W'(1);
      yok[c] = !(c == 0 && in_pixel_row == '0) && (pos < height_r);
    end
    for (int c = 0; c < 3; c++) begin
      wt_nxt[c]     = (xok[c] && yok[0]) ? wtop_r[c*WEIGHT_BITS +: WEIGHT_BITS] : '0;
      wt_nxt[3 + c] = (xok[c] && yok[1]) ? wmid_r[c*WEIGHT_BITS +: WEIGHT_BITS] : '0;
      wt_nxt[6 + c] = (xok[c] && yok[2]) ? wbot_r[c*WEIGHT_BITS +: WEIGHT_BITS] : '0;
    end
    norm_nxt = '0;
    for (int t = 0; t < TAPS; t++) begin
      norm_nxt = norm_nxt + NORM_W'(wt_r[t]);
    end
  end

  // side pipeline: weights, weight sum, centre samples and alpha
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      wt_r        <= wt_nxt;
      ctr_r[0][0] <= in_red_level[SAMPLE_BITS +: SAMPLE_BITS];
      ctr_r[0][1] <= in_green_level[SAMPLE_BITS +: SAMPLE_BITS];
      ctr_r[0][2] <= in_blue_level[SAMPLE_BITS +: SAMPLE_BITS];
      alpha_r[0]  <= in_center_alpha;
    end
    if (ctrl.en[1]) begin
      norm_r[1] <= norm_nxt;
      zero_r[1] <= (norm_nxt == '0);
    end
    for (int k = 1; k < NST; k++) begin
      if (ctrl.en[k]) begin
        ctr_r[k]   <= ctr_r[k-1];
        alpha_r[k] <= alpha_r[k-1];
      end
    end
    for (int k = 2; k < NST; k++) begin
      if (ctrl.en[k]) zero_r[k] <= zero_r[k-1];
    end
    for (int k = 2; k < NST - 1; k++) begin
      if (ctrl.en[k]) norm_r[k] <= norm_r[k-1];
    end
  end

  // channel lanes
  nb3_lane u_lane_red (
    .clk(clk), .ctrl(ctrl), .in_above(in_red_above), .in_level(in_red_level),
    .in_below(in_red_below), .wt_s0(wt_r), .norm_st(norm_r), .quot(q_red)
  );
  nb3_lane u_lane_green (
    .clk(clk), .ctrl(ctrl), .in_above(in_green_above), .in_level(in_green_level),
    .in_below(in_green_below), .wt_s0(wt_r), .norm_st(norm_r), .quot(q_green)
  );
  nb3_lane u_lane_blue (
    .clk(clk), .ctrl(ctrl), .in_above(in_blue_above), .in_level(in_blue_level),
    .in_below(in_blue_below), .wt_s0(wt_r), .norm_st(norm_r), .quot(q_blue)
  );

  // merge lanes, centre samples replace quotients when no weight survives
  assign in_ready        = rdy[0];
  assign out_valid       = v_r[NST-1];
  assign out_zero_weight = zero_r[NST-1];
  assign out_alpha_out   = alpha_r[NST-1];
  assign out_red_out     = OUT_W'(zero_r[NST-1] ? ctr_r[NST-1][0] : q_red);
  assign out_green_out   = OUT_W'(zero_r[NST-1] ? ctr_r[NST-1][1] : q_green);
  assign out_blue_out    = OUT_W'(zero_r[NST-1] ? ctr_r[NST-1][2] : q_blue);

endmodule

### src/nb3_checker.sv
// ----------------------------------------------------------------------------
// nb3_checker
// Port-level checks of the normalised 3x3 blur, bound to the top level.
// ----------------------------------------------------------------------------
module nb3_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [nb3_pkg::OUT_W-1:0]      out_red_out,
  input logic [nb3_pkg::OUT_W-1:0]      out_green_out,
  input logic [nb3_pkg::OUT_W-1:0]      out_blue_out,
  input logic [nb3_pkg::ALPHA_W-1:0]    out_alpha_out,
  input logic                           out_zero_weight
);
  import nb3_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_out) &&
    $stable(out_green_out) && $stable(out_blue_out) &&
    $stable(out_alpha_out) && $stable(out_zero_weight))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a taken output frees room for a transaction
  a_ready_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

endmodule

bind normalized_3x3_blur nb3_checker u_nb3_checker (.*);
